[rtl/core/hlfr_pkg.sv]
// Shared types and constants of the header/length frame receiver.
package hlfr_pkg;

  localparam int STORE_DEPTH_DEF = 256;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW        = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_POS  = 2'd2;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h55;
  localparam logic [7:0] LENGTH_POS_RST  = 8'd10;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DONE = 2'd1,
    ST_SYNC = 2'd2,
    ST_OVF  = 2'd3
  } status_t;

  // front to back response
  typedef struct packed {
    status_t    status;
    logic [8:0] frame_len;
    logic       frame_valid;
    logic       ram_sel;
  } rsp_t;

  typedef struct packed {
    status_t    status;
    logic [8:0] frame_len;
    logic       frame_valid;
    logic [7:0] read_data;
  } out_item_t;

endpackage

[rtl/core/hlfr_if.sv]
// Valid/ready channel interfaces for requests and results.
interface hlfr_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;
  logic [7:0] read_index;

  modport source (output valid, func, rx_byte, read_index, input ready);
  modport sink (input valid, func, rx_byte, read_index, output ready);
endinterface

interface hlfr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [8:0] frame_len;
  logic       frame_valid;
  logic [7:0] read_data;

  modport source (output valid, status, frame_len, frame_valid, read_data, input ready);
  modport sink (input valid, status, frame_len, frame_valid, read_data, output ready);
endinterface

[rtl/core/hlfr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module hlfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/hlfr_front.sv]
// Front end: request accept, frame tracking, store access and request classification.
module hlfr_front import hlfr_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  localparam int AW = $clog2(STORE_DEPTH),
  localparam int CW = $clog2(STORE_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  hlfr_in_if.sink               in_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  room,
  output logic                  ram_we,
  output logic [AW-1:0]         ram_waddr,
  output logic [7:0]            ram_wdata,
  output logic [AW-1:0]         ram_raddr,
  output logic                  rsp_v,
  output rsp_t                  rsp
);

  localparam int CMPW = (CW > 10) ? CW : 10;

  logic [7:0]      sync_first_r, sync_second_r, len_pos_r;
  logic [CW-1:0]   bc_r, bc_nxt, bc_inc;
  logic [7:0]      pl_r, pl_nxt, pl_new;
  logic [8:0]      last_r, last_nxt;
  logic            vld_r, vld_nxt;
  logic            rsp_v_r;
  rsp_t            rsp_r;
  status_t         st;
  logic            acc;
  logic            in_range;
  logic            at_len;
  logic [CMPW-1:0] total;

  assign in_ch.ready = room;
  assign acc         = in_ch.valid && in_ch.ready;
  assign bc_inc      = bc_r + CW'(1);
  assign at_len      = CMPW'(bc_r) == CMPW'(len_pos_r);
  assign in_range    = CMPW'(in_ch.read_index) < CMPW'(STORE_DEPTH);
  assign total       = CMPW'(pl_new) + CMPW'(len_pos_r) + CMPW'(1);

  assign ram_waddr = AW'(bc_r);
  assign ram_wdata = in_ch.rx_byte;
  assign ram_raddr = AW'(in_ch.read_index);

  always_comb begin
    bc_nxt   = bc_r;
    pl_nxt   = pl_r;
    pl_new   = pl_r;
    last_nxt = last_r;
    vld_nxt  = vld_r;
    st       = ST_IDLE;
    ram_we   = 1'b0;
    if (acc && !in_ch.func) begin
      if (bc_r >= CW'(STORE_DEPTH)) begin
        bc_nxt  = '0;
        vld_nxt = 1'b0;
        st      = ST_OVF;
      end else begin
        ram_we = 1'b1;
        if ((bc_r == '0 && in_ch.rx_byte != sync_first_r) ||
            (bc_r == CW'(1) && in_ch.rx_byte != sync_second_r)) begin
          bc_nxt = '0;
          st     = ST_SYNC;
        end else begin
          bc_nxt = bc_inc;
          if (at_len) begin
            pl_nxt = in_ch.rx_byte;
            pl_new = in_ch.rx_byte;
          end
          if (at_len && total > CMPW'(STORE_DEPTH)) begin
            bc_nxt  = '0;
            vld_nxt = 1'b0;
            st      = ST_OVF;
          end else if (CMPW'(bc_inc) > CMPW'(len_pos_r)) begin
            if (CMPW'(bc_inc) == total) begin
              last_nxt = 9'(bc_inc);
              bc_nxt   = '0;
              vld_nxt  = 1'b1;
              st       = ST_DONE;
            end else if (CMPW'(bc_inc) > total) begin
              bc_nxt  = '0;
              vld_nxt = 1'b0;
              st      = ST_OVF;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RST;
      sync_second_r <= SYNC_SECOND_RST;
      len_pos_r     <= LENGTH_POS_RST;
      bc_r          <= '0;
      pl_r          <= '0;
      last_r        <= '0;
      vld_r         <= 1'b0;
      rsp_v_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SYNC_FIRST:  sync_first_r  <= cfg_data;
          CFG_SYNC_SECOND: sync_second_r <= cfg_data;
          CFG_LENGTH_POS:  len_pos_r     <= cfg_data;
          default: ;
        endcase
      end
      bc_r    <= bc_nxt;
      pl_r    <= pl_nxt;
      last_r  <= last_nxt;
      vld_r   <= vld_nxt;
      rsp_v_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rsp_r.status      <= st;
      rsp_r.frame_len   <= last_nxt;
      rsp_r.frame_valid <= vld_nxt;
      rsp_r.ram_sel     <= in_ch.func && in_range;
    end
  end

  assign rsp_v = rsp_v_r;
  assign rsp   = rsp_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bc_r <= CW'(STORE_DEPTH))
    else $error("byte count beyond store depth");

  a_done_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (rsp_v_r && rsp_r.status == ST_DONE) |-> rsp_r.frame_valid)
    else $error("completed frame without valid flag");

  a_ovf_clears_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (rsp_v_r && rsp_r.status == ST_OVF) |-> !rsp_r.frame_valid)
    else $error("dropped frame left valid flag set");

  a_status_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (st == ST_DONE || st == ST_SYNC || st == ST_OVF)) |=> bc_r == '0)
    else $error("frame count not restarted");

endmodule

[rtl/core/hlfr_queue.sv]
// Back end: result queue and output channel driver.
module hlfr_queue import hlfr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  rsp_t       push_rsp,
  input  logic [7:0] ram_rdata,
  output logic       room,
  hlfr_out_if.source out_ch
);

  out_item_t             q_r [QUEUE_DEPTH];
  out_item_t             item;
  logic [QUEUE_AW-1:0]   wp_r, rp_r;
  logic [QUEUE_CW-1:0]   cnt_r;
  logic                  pop;

  assign item.status      = push_rsp.status;
  assign item.frame_len   = push_rsp.frame_len;
  assign item.frame_valid = push_rsp.frame_valid;
  assign item.read_data   = push_rsp.ram_sel ? ram_rdata : 8'd0;

  assign room = (cnt_r + QUEUE_CW'(push)) < QUEUE_CW'(QUEUE_DEPTH);
  assign pop  = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + QUEUE_AW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + QUEUE_AW'(1);
      end
      cnt_r <= cnt_r + QUEUE_CW'(push) - QUEUE_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= item;
    end
  end

  assign out_ch.valid       = cnt_r != '0;
  assign out_ch.status      = q_r[rp_r].status;
  assign out_ch.frame_len   = q_r[rp_r].frame_len;
  assign out_ch.frame_valid = q_r[rp_r].frame_valid;
  assign out_ch.read_data   = q_r[rp_r].read_data;

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r < QUEUE_CW'(QUEUE_DEPTH))
    else $error("queue overrun");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + QUEUE_CW'(1))
    else $error("queue count lost a push");

endmodule

[rtl/core/header_length_frame_receiver_core.sv]
// Top level of the header/length frame receiver.
// An accepted request is registered in the front end, together with the store read data,
// and then written into the result queue, whose head drives the output channel.
// Throughput: one request per cycle, sustained while results are taken; a 4-entry
// result queue lets input and output stall independently.
// Reset (rst_n, synchronous): frame count, length, last length, valid flag and queue
// cleared, config set to its defaults; the frame store is not cleared and needs no clearing pass.
module header_length_frame_receiver_core import hlfr_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  hlfr_in_if.sink               in_ch,
  hlfr_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(STORE_DEPTH);

  logic          room;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic          rsp_v;
  rsp_t          rsp;

  hlfr_front #(.STORE_DEPTH(STORE_DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .room      (room),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .rsp_v     (rsp_v),
    .rsp       (rsp)
  );

  hlfr_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hlfr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rsp_v),
    .push_rsp  (rsp),
    .ram_rdata (ram_rdata),
    .room      (room),
    .out_ch    (out_ch)
  );

endmodule
